>>> src/rtcc_pkg.sv
// Package for the epoch-seconds calendar counter: command and status codes,
// sequencer states, shared adder request/response types and calendar constants.
// No dependencies.
`default_nettype none

package rtcc_pkg;

  // Command codes carried by an input request. Code 3 is unused and acts as a read.
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  // Status codes returned with every result.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Calendar constants.
  localparam logic [31:0] SECS_LEAP_YEAR   = 32'd31622400;
  localparam logic [31:0] SECS_COMMON_YEAR = 32'd31536000;
  localparam logic [31:0] SECS_PER_DAY     = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR    = 32'd3600;
  localparam logic [31:0] SECS_PER_MINUTE  = 32'd60;
  localparam logic [31:0] SECS_ONE         = 32'd1;
  localparam logic [11:0] FIRST_YEAR       = 12'd1970;
  localparam logic [11:0] LAST_YEAR        = 12'd2099;
  localparam logic [11:0] SKIPPED_LEAP     = 12'd2100;
  localparam logic [3:0]  LAST_MONTH0      = 4'd11;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_YEAR,
    ST_E_MONTH,
    ST_E_DAY,
    ST_E_DAYFIX,
    ST_E_HOUR,
    ST_E_MIN,
    ST_E_SEC,
    ST_D_YEAR,
    ST_D_MONTH,
    ST_D_DAY,
    ST_D_HOUR,
    ST_D_MIN,
    ST_DONE
  } state_e;

  // Request to and response from the shared adder/subtractor.
  typedef struct packed {
    logic        sub;
    logic [31:0] a;
    logic [31:0] k;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        ge;
  } alu_rsp_t;

  // Leap-year test. Exact over 1970..2106, where 2100 is the only century
  // that is not a leap year.
  function automatic logic is_leap(input logic [11:0] y);
    is_leap = (y[1:0] == 2'b00) && (y != SKIPPED_LEAP);
  endfunction

  // Length of a year in seconds.
  function automatic logic [31:0] year_secs(input logic [11:0] y);
    year_secs = is_leap(y) ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
  endfunction

  // Length of a month in seconds; m0 counts from 0 for January.
  function automatic logic [31:0] month_secs(input logic [3:0] m0, input logic leap);
    logic [31:0] secs;
    case (m0)
      4'd1:    secs = leap ? 32'd2505600 : 32'd2419200;
      4'd3,
      4'd5,
      4'd8,
      4'd10:   secs = 32'd2592000;
      default: secs = 32'd2678400;
    endcase
    month_secs = secs;
  endfunction

endpackage

`default_nettype wire

>>> src/rtcc_in_if.sv
// Input channel of the calendar counter: valid/ready plus the command request.
// Depends on nothing.
`default_nettype none

interface rtcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] set_year;
  logic [3:0]  set_month;
  logic [4:0]  set_day;
  logic [4:0]  set_hour;
  logic [5:0]  set_minute;
  logic [5:0]  set_second;

  modport source (
    output valid, cmd, set_year, set_month, set_day, set_hour, set_minute, set_second,
    input  ready
  );
  modport sink (
    input  valid, cmd, set_year, set_month, set_day, set_hour, set_minute, set_second,
    output ready
  );
endinterface

`default_nettype wire

>>> src/rtcc_out_if.sv
// Output channel of the calendar counter: valid/ready plus the decoded result.
// Depends on nothing.
`default_nettype none

interface rtcc_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [31:0] seconds_count;

  modport source (
    output valid, status, out_year, out_month, out_day, out_hour, out_minute,
           out_second, seconds_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_year, out_month, out_day, out_hour, out_minute,
           out_second, seconds_count,
    output ready
  );
endinterface

`default_nettype wire

>>> src/rtcc_addsub.sv
// Shared 32-bit adder/subtractor of the calendar counter sequencer.
// Depends on rtcc_pkg for the request and response types.
`default_nettype none

module rtcc_addsub (
  input  rtcc_pkg::alu_req_t req_i,
  output rtcc_pkg::alu_rsp_t rsp_o
);

  logic [31:0] operand;
  logic [32:0] total;

  // Subtraction adds the inverted operand plus one; the carry out then means a >= k.
  always_comb begin
    operand   = req_i.sub ? ~req_i.k : req_i.k;
    total     = {1'b0, req_i.a} + {1'b0, operand} + {32'd0, req_i.sub};
    rsp_o.sum = total[31:0];
    rsp_o.ge  = total[32];
  end

endmodule

`default_nettype wire

>>> src/rtc_epoch_calendar_counter_unit.sv
// Top level of the epoch-seconds calendar counter: sequencer, state and result register.
// Depends on rtcc_pkg, rtcc_in_if, rtcc_out_if and rtcc_addsub.
`default_nettype none

//  Channel    Port       Direction  Moves
//  -------    ---------  ---------  ------------------------------------------
//  command    cmd_ch_i   in         tick / set / read request with set fields
//  result     res_ch_o   out        status, decoded calendar, seconds count
//
//  One request is taken at a time. A tick or read steps once for each whole
//  year, month, day, hour and minute that the decode walks past. A set first
//  steps once for each year after 1970 and each month, day, hour and minute
//  given. All steps go through the single 32-bit adder/subtractor, one step
//  per cycle. The result is held in an output register, so a stalled result
//  blocks only the next request's final step. Reset clears the count to
//  1970-01-01 00:00:00.

module rtc_epoch_calendar_counter_unit (
  input  wire     clk_i,
  input  wire     rst_ni,
  rtcc_in_if.sink    cmd_ch_i,
  rtcc_out_if.source res_ch_o
);

  rtcc_pkg::state_e   state_q, state_d;
  rtcc_pkg::alu_req_t alu_req;
  rtcc_pkg::alu_rsp_t alu_rsp;

  // Control state and the epoch count.
  logic [31:0] count_q, count_d;
  logic        out_valid_q, out_valid_d;

  // Working registers.
  logic [31:0] r_q, r_d;
  logic [11:0] yr_q, yr_d;
  logic [3:0]  m_q, m_d;
  logic [4:0]  d_q, d_d;
  logic [4:0]  h_q, h_d;
  logic [5:0]  mi_q, mi_d;
  logic [5:0]  n_q, n_d;
  logic        status_q, status_d;

  // Captured set fields.
  logic [11:0] set_year_q;
  logic [3:0]  set_month_q;
  logic [4:0]  set_day_q;
  logic [4:0]  set_hour_q;
  logic [5:0]  set_minute_q;
  logic [5:0]  set_second_q;

  // Result register.
  logic        res_status_q;
  logic [11:0] res_year_q;
  logic [3:0]  res_month_q;
  logic [4:0]  res_day_q;
  logic [4:0]  res_hour_q;
  logic [5:0]  res_minute_q;
  logic [5:0]  res_second_q;
  logic [31:0] res_count_q;

  logic        in_fire;
  logic        year_ok;
  logic        res_load;
  logic [3:0]  month_clamped;
  logic        month_more;

  assign in_fire  = cmd_ch_i.valid && cmd_ch_i.ready;
  assign year_ok  = cmd_ch_i.set_year inside {[rtcc_pkg::FIRST_YEAR:rtcc_pkg::LAST_YEAR]};
  assign res_load = (state_q == rtcc_pkg::ST_DONE) && (!out_valid_q || res_ch_o.ready);

  // The set month is clamped into 1..12 before the month walk.
  always_comb begin
    if (set_month_q == 4'd0) begin
      month_clamped = 4'd1;
    end else if (set_month_q > 4'd12) begin
      month_clamped = 4'd12;
    end else begin
      month_clamped = set_month_q;
    end
    month_more = ({1'b0, m_q} + 5'd1) < {1'b0, month_clamped};
  end

  rtcc_addsub u_addsub (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rtcc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if ((cmd_ch_i.cmd == rtcc_pkg::CMD_SET) && year_ok) begin
            state_d = rtcc_pkg::ST_E_YEAR;
          end else begin
            state_d = rtcc_pkg::ST_D_YEAR;
          end
        end
      end
      rtcc_pkg::ST_E_YEAR: begin
        if (yr_q == set_year_q) state_d = rtcc_pkg::ST_E_MONTH;
      end
      rtcc_pkg::ST_E_MONTH: begin
        if (!month_more) state_d = rtcc_pkg::ST_E_DAY;
      end
      rtcc_pkg::ST_E_DAY: begin
        if (n_q == 6'd0) state_d = rtcc_pkg::ST_E_DAYFIX;
      end
      rtcc_pkg::ST_E_DAYFIX: state_d = rtcc_pkg::ST_E_HOUR;
      rtcc_pkg::ST_E_HOUR: begin
        if (n_q == 6'd0) state_d = rtcc_pkg::ST_E_MIN;
      end
      rtcc_pkg::ST_E_MIN: begin
        if (n_q == 6'd0) state_d = rtcc_pkg::ST_E_SEC;
      end
      rtcc_pkg::ST_E_SEC: state_d = rtcc_pkg::ST_D_YEAR;
      rtcc_pkg::ST_D_YEAR: begin
        if (!alu_rsp.ge) state_d = rtcc_pkg::ST_D_MONTH;
      end
      rtcc_pkg::ST_D_MONTH: begin
        if (!alu_rsp.ge || (m_q == rtcc_pkg::LAST_MONTH0)) state_d = rtcc_pkg::ST_D_DAY;
      end
      rtcc_pkg::ST_D_DAY: begin
        if (!alu_rsp.ge) state_d = rtcc_pkg::ST_D_HOUR;
      end
      rtcc_pkg::ST_D_HOUR: begin
        if (!alu_rsp.ge) state_d = rtcc_pkg::ST_D_MIN;
      end
      rtcc_pkg::ST_D_MIN: begin
        if (!alu_rsp.ge) state_d = rtcc_pkg::ST_DONE;
      end
      rtcc_pkg::ST_DONE: begin
        if (res_load) state_d = rtcc_pkg::ST_IDLE;
      end
      default: state_d = rtcc_pkg::ST_IDLE;
    endcase
  end

  // Datapath control: adder request and working register updates per state.
  always_comb begin
    alu_req     = '{sub: 1'b0, a: r_q, k: rtcc_pkg::SECS_ONE};
    count_d     = count_q;
    r_d         = r_q;
    yr_d        = yr_q;
    m_d         = m_q;
    d_d         = d_q;
    h_d         = h_q;
    mi_d        = mi_q;
    n_d         = n_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;

    if (res_ch_o.ready) out_valid_d = 1'b0;
    if (res_load) out_valid_d = 1'b1;

    case (state_q)
      rtcc_pkg::ST_IDLE: begin
        alu_req.a = count_q;
        if (in_fire) begin
          status_d = rtcc_pkg::STATUS_OK;
          yr_d     = rtcc_pkg::FIRST_YEAR;
          r_d      = count_q;
          case (cmd_ch_i.cmd)
            rtcc_pkg::CMD_TICK: begin
              count_d = alu_rsp.sum;
              r_d     = alu_rsp.sum;
            end
            rtcc_pkg::CMD_SET: begin
              if (year_ok) begin
                r_d = 32'd0;
              end else begin
                status_d = rtcc_pkg::STATUS_BAD;
              end
            end
            default: ;
          endcase
        end
      end
      // Encode: accumulate whole years, months, days, hours and minutes, then the seconds.
      rtcc_pkg::ST_E_YEAR: begin
        alu_req.k = rtcc_pkg::year_secs(yr_q);
        m_d       = 4'd0;
        if (yr_q != set_year_q) begin
          r_d  = alu_rsp.sum;
          yr_d = yr_q + 12'd1;
        end
      end
      rtcc_pkg::ST_E_MONTH: begin
        alu_req.k = rtcc_pkg::month_secs(m_q, rtcc_pkg::is_leap(set_year_q));
        if (month_more) begin
          r_d = alu_rsp.sum;
          m_d = m_q + 4'd1;
        end else begin
          n_d = {1'b0, set_day_q};
        end
      end
      rtcc_pkg::ST_E_DAY: begin
        alu_req.k = rtcc_pkg::SECS_PER_DAY;
        if (n_q != 6'd0) begin
          r_d = alu_rsp.sum;
          n_d = n_q - 6'd1;
        end
      end
      // Days count from one, so one day is taken back; day zero wraps as given.
      rtcc_pkg::ST_E_DAYFIX: begin
        alu_req.sub = 1'b1;
        alu_req.k   = rtcc_pkg::SECS_PER_DAY;
        r_d         = alu_rsp.sum;
        n_d         = {1'b0, set_hour_q};
      end
      rtcc_pkg::ST_E_HOUR: begin
        alu_req.k = rtcc_pkg::SECS_PER_HOUR;
        if (n_q != 6'd0) begin
          r_d = alu_rsp.sum;
          n_d = n_q - 6'd1;
        end else begin
          n_d = set_minute_q;
        end
      end
      rtcc_pkg::ST_E_MIN: begin
        alu_req.k = rtcc_pkg::SECS_PER_MINUTE;
        if (n_q != 6'd0) begin
          r_d = alu_rsp.sum;
          n_d = n_q - 6'd1;
        end
      end
      rtcc_pkg::ST_E_SEC: begin
        alu_req.k = {26'd0, set_second_q};
        r_d       = alu_rsp.sum;
        count_d   = alu_rsp.sum;
        yr_d      = rtcc_pkg::FIRST_YEAR;
      end
      // Decode: strip whole years, months, days, hours and minutes.
      rtcc_pkg::ST_D_YEAR: begin
        alu_req.sub = 1'b1;
        alu_req.k   = rtcc_pkg::year_secs(yr_q);
        m_d         = 4'd0;
        if (alu_rsp.ge) begin
          r_d  = alu_rsp.sum;
          yr_d = yr_q + 12'd1;
        end
      end
      rtcc_pkg::ST_D_MONTH: begin
        alu_req.sub = 1'b1;
        alu_req.k   = rtcc_pkg::month_secs(m_q, rtcc_pkg::is_leap(yr_q));
        d_d         = 5'd0;
        if (alu_rsp.ge && (m_q != rtcc_pkg::LAST_MONTH0)) begin
          r_d = alu_rsp.sum;
          m_d = m_q + 4'd1;
        end
      end
      rtcc_pkg::ST_D_DAY: begin
        alu_req.sub = 1'b1;
        alu_req.k   = rtcc_pkg::SECS_PER_DAY;
        h_d         = 5'd0;
        if (alu_rsp.ge) begin
          r_d = alu_rsp.sum;
          d_d = d_q + 5'd1;
        end
      end
      rtcc_pkg::ST_D_HOUR: begin
        alu_req.sub = 1'b1;
        alu_req.k   = rtcc_pkg::SECS_PER_HOUR;
        mi_d        = 6'd0;
        if (alu_rsp.ge) begin
          r_d = alu_rsp.sum;
          h_d = h_q + 5'd1;
        end
      end
      rtcc_pkg::ST_D_MIN: begin
        alu_req.sub = 1'b1;
        alu_req.k   = rtcc_pkg::SECS_PER_MINUTE;
        if (alu_rsp.ge) begin
          r_d  = alu_rsp.sum;
          mi_d = mi_q + 6'd1;
        end
      end
      default: ;
    endcase
  end

  // Control state and the epoch count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtcc_pkg::ST_IDLE;
      count_q     <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and captured request fields.
  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    yr_q     <= yr_d;
    m_q      <= m_d;
    d_q      <= d_d;
    h_q      <= h_d;
    mi_q     <= mi_d;
    n_q      <= n_d;
    status_q <= status_d;
    if (in_fire) begin
      set_year_q   <= cmd_ch_i.set_year;
      set_month_q  <= cmd_ch_i.set_month;
      set_day_q    <= cmd_ch_i.set_day;
      set_hour_q   <= cmd_ch_i.set_hour;
      set_minute_q <= cmd_ch_i.set_minute;
      set_second_q <= cmd_ch_i.set_second;
    end
  end

  // Result register, loaded when the decode is done and the slot is free.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_status_q <= status_q;
      res_year_q   <= yr_q;
      res_month_q  <= m_q + 4'd1;
      res_day_q    <= d_q + 5'd1;
      res_hour_q   <= h_q;
      res_minute_q <= mi_q;
      res_second_q <= r_q[5:0];
      res_count_q  <= count_q;
    end
  end

  assign cmd_ch_i.ready         = (state_q == rtcc_pkg::ST_IDLE);
  assign res_ch_o.valid         = out_valid_q;
  assign res_ch_o.status        = res_status_q;
  assign res_ch_o.out_year      = res_year_q;
  assign res_ch_o.out_month     = res_month_q;
  assign res_ch_o.out_day       = res_day_q;
  assign res_ch_o.out_hour      = res_hour_q;
  assign res_ch_o.out_minute    = res_minute_q;
  assign res_ch_o.out_second    = res_second_q;
  assign res_ch_o.seconds_count = res_count_q;

endmodule

`default_nettype wire
